// ===== rtl/rcsh_pkg.sv =====
// ----------------------------------------------------------------------------
// RGB channel select package
// Types, opcodes and constants shared by the channel selector modules.
// ----------------------------------------------------------------------------
package rcsh_pkg;

    localparam int unsigned QuotW = 8;
    localparam int unsigned NumW  = 17;
    localparam int unsigned DivW  = 9;

    typedef enum logic [3:0] {
        OP_RED     = 4'd0,
        OP_GREEN   = 4'd1,
        OP_BLUE    = 4'd2,
        OP_HUE     = 4'd3,
        OP_SAT     = 4'd4,
        OP_BRIGHT  = 4'd5,
        OP_CYAN    = 4'd6,
        OP_MAGENTA = 4'd7,
        OP_YELLOW  = 4'd8
    } t_opcode;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [3:0] opcode;
    } t_in_item;

    typedef struct packed {
        logic [7:0] channel_value;
        logic       error_code;
    } t_out_item;

    // Item travelling through the divider cells.
    typedef struct packed {
        logic [NumW-1:0] sat_rem;
        logic [DivW-1:0] sat_div;
        logic [QuotW-1:0] sat_q;
        logic [NumW-1:0] hue_rem;
        logic [DivW-1:0] hue_div;
        logic [QuotW-1:0] hue_q;
        logic            hue_neg;
        logic            hue_zero;
        logic [7:0]      direct;
        logic [1:0]      sel;
        logic            error_code;
    } t_cell_data;

    localparam logic [1:0] SEL_DIRECT = 2'd0;
    localparam logic [1:0] SEL_HUE    = 2'd1;
    localparam logic [1:0] SEL_SAT    = 2'd2;

endpackage

// ===== rtl/rgb_channel_select_hsv.sv =====
// Each item passes through one front stage, eight divider cells and one
// output stage. Throughput: one item per cycle while i_stall does not hold
// the full output stage, set by the chain of eight one-bit divider cells.
// The chain advances whenever the output stage is free. Reset empties it.
// ----------------------------------------------------------------------------
// RGB channel select with HSV
// Gives R/G/B, hue, saturation, brightness, a two-channel mean or an error.
// ----------------------------------------------------------------------------
module rgb_channel_select_hsv (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  rcsh_pkg::t_in_item   i_item,
    output logic                 o_valid,
    input  logic                 i_stall,
    output rcsh_pkg::t_out_item  o_item
);

    localparam int unsigned N = rcsh_pkg::QuotW;

    logic                 w_en;
    logic                 r_fvalid;
    rcsh_pkg::t_cell_data r_fdata;
    rcsh_pkg::t_cell_data n_fdata;
    logic                 w_cv [0:N];
    rcsh_pkg::t_cell_data w_cd [0:N];
    logic                 r_ovalid;
    rcsh_pkg::t_out_item  r_oitem;
    rcsh_pkg::t_out_item  n_oitem;

    logic [7:0] w_r, w_g, w_b, w_mx, w_mn, w_d, w_pos, w_neg, w_base;
    logic [16:0] w_pnum;
    logic [14:0] w_nnum;

    assign w_en    = !(r_ovalid && i_stall);
    assign o_stall = !w_en;

    always_comb begin
        w_r = i_item.red;
        w_g = i_item.green;
        w_b = i_item.blue;
        w_mx = w_r;
        if (w_g > w_mx) w_mx = w_g;
        if (w_b > w_mx) w_mx = w_b;
        w_mn = w_r;
        if (w_g < w_mn) w_mn = w_g;
        if (w_b < w_mn) w_mn = w_b;
        w_d = w_mx - w_mn;
        if (w_r == w_mx) begin
            w_base = 8'd0;   w_pos = w_g; w_neg = w_b;
        end else if (w_g == w_mx) begin
            w_base = 8'd1;   w_pos = w_b; w_neg = w_r;
        end else begin
            w_base = 8'd2;   w_pos = w_r; w_neg = w_g;
        end
        // base*170*d is 0, 170*d or 340*d, added to pos*85.
        w_pnum = 17'(w_pos) * 17'd85 + 17'(w_base) * 17'(w_d) * 17'd170;
        w_nnum = 15'(w_neg) * 15'd85;
        n_fdata = '0;
        n_fdata.hue_zero = (w_d == 8'd0);
        n_fdata.hue_div  = {w_d, 1'b0};
        n_fdata.hue_neg  = 17'(w_nnum) > w_pnum;
        n_fdata.hue_rem  = n_fdata.hue_neg ? 17'(w_nnum) - w_pnum
                                           : w_pnum - 17'(w_nnum);
        n_fdata.sat_div  = {1'b0, w_mx};
        n_fdata.sat_rem  = 17'({w_d, 8'd0} - 16'(w_d));
        n_fdata.sel      = rcsh_pkg::SEL_DIRECT;
        case (i_item.opcode)
            rcsh_pkg::OP_RED:     n_fdata.direct = w_r;
            rcsh_pkg::OP_GREEN:   n_fdata.direct = w_g;
            rcsh_pkg::OP_BLUE:    n_fdata.direct = w_b;
            rcsh_pkg::OP_HUE:     n_fdata.sel = rcsh_pkg::SEL_HUE;
            rcsh_pkg::OP_SAT:     n_fdata.sel = rcsh_pkg::SEL_SAT;
            rcsh_pkg::OP_BRIGHT:  n_fdata.direct = w_mx;
            rcsh_pkg::OP_CYAN:    n_fdata.direct = 8'((9'(w_g) + 9'(w_b)) >> 1);
            rcsh_pkg::OP_MAGENTA: n_fdata.direct = 8'((9'(w_r) + 9'(w_b)) >> 1);
            rcsh_pkg::OP_YELLOW:  n_fdata.direct = 8'((9'(w_r) + 9'(w_g)) >> 1);
            default:              n_fdata.error_code = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fvalid <= 1'b0;
        end else if (w_en) begin
            r_fvalid <= i_valid;
        end
        if (w_en) begin
            r_fdata <= n_fdata;
        end
    end

    assign w_cv[N] = r_fvalid;
    assign w_cd[N] = r_fdata;

    for (genvar k = 0; k < N; k++) begin : g_cell
        rcsh_cell #(.BIT(k)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_cv[k+1]),
            .i_data  (w_cd[k+1]),
            .o_valid (w_cv[k]),
            .o_data  (w_cd[k])
        );
    end

    always_comb begin
        n_oitem.error_code = w_cd[0].error_code;
        case (w_cd[0].sel)
            rcsh_pkg::SEL_HUE: begin
                if (w_cd[0].hue_zero) begin
                    n_oitem.channel_value = 8'd0;
                end else if (w_cd[0].hue_neg && w_cd[0].hue_q != 8'd0) begin
                    n_oitem.channel_value = 8'd255 - w_cd[0].hue_q;
                end else begin
                    n_oitem.channel_value = w_cd[0].hue_q;
                end
            end
            rcsh_pkg::SEL_SAT: begin
                n_oitem.channel_value = (w_cd[0].sat_div == '0) ? 8'd0 : w_cd[0].sat_q;
            end
            default: n_oitem.channel_value = w_cd[0].direct;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_en) begin
            r_ovalid <= w_cv[0];
        end
        if (w_en) begin
            r_oitem <= n_oitem;
        end
    end

    assign o_valid = r_ovalid;
    assign o_item  = r_oitem;

endmodule

// ===== rtl/rcsh_cell.sv =====
// ----------------------------------------------------------------------------
// Divider cell
// One restoring quotient bit for both the hue and the saturation division.
// ----------------------------------------------------------------------------
module rcsh_cell #(
    parameter int unsigned BIT = 0
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  rcsh_pkg::t_cell_data  i_data,
    output logic                  o_valid,
    output rcsh_pkg::t_cell_data  o_data
);

    logic                 r_valid;
    rcsh_pkg::t_cell_data r_data;
    rcsh_pkg::t_cell_data n_data;
    logic [rcsh_pkg::NumW-1:0] w_hsub;
    logic [rcsh_pkg::NumW-1:0] w_ssub;

    assign w_hsub = rcsh_pkg::NumW'(i_data.hue_div) << BIT;
    assign w_ssub = rcsh_pkg::NumW'(i_data.sat_div) << BIT;

    always_comb begin
        n_data = i_data;
        if (i_data.hue_rem >= w_hsub) begin
            n_data.hue_rem     = i_data.hue_rem - w_hsub;
            n_data.hue_q[BIT]  = 1'b1;
        end
        if (i_data.sat_rem >= w_ssub) begin
            n_data.sat_rem     = i_data.sat_rem - w_ssub;
            n_data.sat_q[BIT]  = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ===== bench/rgb_channel_select_hsv_checker.sv =====
// ----------------------------------------------------------------------------
// RGB channel select checker
// Watches both channels of the channel selector, predicts each result from
// the accepted pixel and opcode, and compares results in order.
// ----------------------------------------------------------------------------
module rgb_channel_select_hsv_checker (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic                 i_stall,
    input  rcsh_pkg::t_in_item   i_item,
    input  logic                 o_valid,
    input  logic                 o_stall,
    input  rcsh_pkg::t_out_item  o_item,
    output int                   o_fail_count,
    output int                   o_pending
);

    rcsh_pkg::t_out_item expected_q[$];

    function automatic logic [7:0] hue_value(logic [7:0] r, logic [7:0] g, logic [7:0] b);
        int mx, mn, d2, base, diff, num, q;
        mx = r; mn = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        if (mx == mn) return 8'd0;
        d2 = 2 * (mx - mn);
        if (r == mx) begin
            base = 0; diff = int'(g) - int'(b);
        end else if (g == mx) begin
            base = 85; diff = int'(b) - int'(r);
        end else begin
            base = 170; diff = int'(r) - int'(g);
        end
        num = base * d2 + diff * 85;
        q = (num < 0 ? -num : num) / d2;
        if (num < 0 && q != 0) return 8'(255 - q);
        return 8'(q);
    endfunction

    function automatic rcsh_pkg::t_out_item channel_of(rcsh_pkg::t_in_item px);
        rcsh_pkg::t_out_item res;
        int mx, mn;
        mx = px.red; mn = px.red;
        if (px.green > mx) mx = px.green;
        if (px.blue > mx) mx = px.blue;
        if (px.green < mn) mn = px.green;
        if (px.blue < mn) mn = px.blue;
        res = '0;
        case (px.opcode)
            rcsh_pkg::OP_RED:     res.channel_value = px.red;
            rcsh_pkg::OP_GREEN:   res.channel_value = px.green;
            rcsh_pkg::OP_BLUE:    res.channel_value = px.blue;
            rcsh_pkg::OP_HUE:     res.channel_value = hue_value(px.red, px.green, px.blue);
            rcsh_pkg::OP_SAT:
                res.channel_value = (mx == 0) ? 8'd0 : 8'(((mx - mn) * 255) / mx);
            rcsh_pkg::OP_BRIGHT:  res.channel_value = 8'(mx);
            rcsh_pkg::OP_CYAN:
                res.channel_value = 8'((int'(px.green) + int'(px.blue)) >> 1);
            rcsh_pkg::OP_MAGENTA:
                res.channel_value = 8'((int'(px.red) + int'(px.blue)) >> 1);
            rcsh_pkg::OP_YELLOW:
                res.channel_value = 8'((int'(px.red) + int'(px.green)) >> 1);
            default:              res.error_code = 1'b1;
        endcase
        return res;
    endfunction

    assign o_pending = expected_q.size();

    initial o_fail_count = 0;

    always @(posedge i_clk) begin
        rcsh_pkg::t_out_item want;
        if (i_rst_n) begin
            if (i_valid && !o_stall) expected_q.push_back(channel_of(i_item));
            if (o_valid && !i_stall) begin
                if (expected_q.size() == 0) begin
                    $error("unexpected result: channel_value %0d error_code %0d",
                           o_item.channel_value, o_item.error_code);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = expected_q.pop_front();
                    if (want.channel_value !== o_item.channel_value) begin
                        $error("channel_value: expected %0d actual %0d",
                               want.channel_value, o_item.channel_value);
                        o_fail_count <= o_fail_count + 1;
                    end else if (want.error_code !== o_item.error_code) begin
                        $error("error_code: expected %0d actual %0d",
                               want.error_code, o_item.error_code);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

// ===== bench/tb_rgb_channel_select_hsv.sv =====
// ----------------------------------------------------------------------------
// RGB channel select testbench
// Drives directed and random pixels with bursty input and a stalling output,
// and reports the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module tb_rgb_channel_select_hsv;

    localparam int NumRandom = 2000;
    localparam int CycleLimit = 200000;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_valid;
    logic                i_stall;
    rcsh_pkg::t_in_item  i_item;
    logic                o_stall;
    logic                o_valid;
    rcsh_pkg::t_out_item o_item;
    int                  fail_count;
    int                  pending;
    int                  cycle_count;

    rgb_channel_select_hsv dut (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_item, .o_valid, .i_stall, .o_item
    );

    rgb_channel_select_hsv_checker checker_inst (
        .i_clk, .i_rst_n, .i_valid, .i_stall, .i_item, .o_valid, .o_stall, .o_item,
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        cycle_count = 0;
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count >= CycleLimit) begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // Receiver: a long hold-off early on, then random stall patterns.
    initial begin
        int mode;
        i_stall = 1'b1;
        repeat (60) @(negedge i_clk);
        forever begin
            mode = $urandom_range(0, 3);
            repeat ($urandom_range(5, 40)) begin
                @(negedge i_clk);
                case (mode)
                    0: i_stall <= 1'b0;
                    1: i_stall <= ($urandom_range(0, 3) == 0);
                    2: i_stall <= ($urandom_range(0, 1) == 0);
                    default: i_stall <= ($urandom_range(0, 4) != 0);
                endcase
            end
        end
    end

    task automatic send_item(rcsh_pkg::t_in_item px);
        i_item <= px;
        i_valid <= 1'b1;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic send_burst_end();
        i_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge i_clk);
    endtask

    function automatic rcsh_pkg::t_in_item random_pixel();
        rcsh_pkg::t_in_item px;
        px.red = 8'($urandom);
        px.green = 8'($urandom);
        px.blue = 8'($urandom);
        case ($urandom_range(0, 5))
            0: px.green = px.red;
            1: px.blue = px.red;
            2: begin px.green = px.red; px.blue = px.red; end
            3: px.red = 8'($urandom_range(0, 1) ? 8'hFF : 8'h00);
            default: ;
        endcase
        px.opcode = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(9, 15))
                                                : 4'($urandom_range(0, 8));
        return px;
    endfunction

    initial begin
        rcsh_pkg::t_in_item px;
        int sent;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_item = '0;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        // Directed pixels: black, white, primaries, ties between maxima,
        // negative hue wrap and every opcode including unsupported ones.
        for (int op = 0; op < 16; op++) begin
            case (op % 8)
                0: px = '{8'h00, 8'h00, 8'h00, 4'(op)};
                1: px = '{8'hFF, 8'hFF, 8'hFF, 4'(op)};
                2: px = '{8'hFF, 8'h00, 8'h01, 4'(op)};
                3: px = '{8'h00, 8'hFF, 8'h00, 4'(op)};
                4: px = '{8'h01, 8'h00, 8'hFF, 4'(op)};
                5: px = '{8'hFF, 8'hFF, 8'h00, 4'(op)};
                6: px = '{8'h00, 8'hFF, 8'hFF, 4'(op)};
                default: px = '{8'hAA, 8'h55, 8'hFE, 4'(op)};
            endcase
            send_item(px);
        end
        send_item('{8'hFF, 8'h00, 8'h01, rcsh_pkg::OP_HUE});
        send_item('{8'h01, 8'h00, 8'h01, rcsh_pkg::OP_HUE});
        send_item('{8'hFF, 8'h00, 8'hFF, rcsh_pkg::OP_HUE});
        send_item('{8'h80, 8'h7F, 8'h80, rcsh_pkg::OP_SAT});
        send_item('{8'h55, 8'hAA, 8'h55, rcsh_pkg::OP_HUE});
        send_burst_end();
        sent = 0;
        while (sent < NumRandom) begin
            repeat ($urandom_range(1, 30)) begin
                send_item(random_pixel());
                sent++;
            end
            send_burst_end();
        end
        i_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule

// ===== rgb_channel_select_hsv.f =====
rtl/rcsh_pkg.sv
rtl/rcsh_cell.sv
rtl/rgb_channel_select_hsv.sv
bench/rgb_channel_select_hsv_checker.sv
bench/tb_rgb_channel_select_hsv.sv
